### hdl/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the transitive closure engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int ROW_W  = 32;  // adjacency / closure row width
  localparam int VIDX_W = 5;   // vertex index width
  localparam int CFG_W  = 6;   // vertex_count register width

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 6'd32;

  typedef logic [ROW_W-1:0] row_t;

  // Lane control, broadcast from the sequencer to every lane.
  typedef struct packed {
    logic              load_en;   // write wdata into the lane matching sel
    logic              close_en;  // one pivot step with pivot index sel
    logic [VIDX_W-1:0] sel;       // row being loaded, or current pivot
  } lane_ctrl_t;

endpackage

### hdl/transitive_closure_engine.sv
`timescale 1ns / 1ps
// N input transfers load the matrix (N = effective vertex count), then the
// closure runs one pivot per cycle over all row lanes, and the result rows
// are then registered out one row per cycle while the receiver accepts them.
// New rows are accepted only once the previous matrix is fully registered out.
// Reset (synchronous, rst_n low): vertex_count = 32, load restarts at row 0,
// no result pending. Matrix rows are not cleared.
// ----------------------------------------------------------------------------
// transitive_closure_engine
// Warshall transitive closure over a row-per-lane register matrix.
// ----------------------------------------------------------------------------
module transitive_closure_engine #(
  parameter int MAX_VERTICES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write: vertex_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // input stream; tdata: [31:0] adjacency_row
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // output stream; tdata: [31:0] closure_row, [36:32] source_vertex, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast    // final_row
);

  localparam int ROWS  = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int CNT_W = $clog2(ROWS + 1);

  typedef enum logic [1:0] {ST_LOAD, ST_CLOSE, ST_EMIT} state_t;

  state_t                         state_r;
  logic [tce_pkg::CFG_W-1:0]      vcount_r;
  logic [CNT_W-1:0]               idx_r;
  logic                           out_valid_r;
  tce_pkg::row_t                  out_row_r;
  logic [tce_pkg::VIDX_W-1:0]     out_vtx_r;
  logic                           out_last_r;

  logic [CNT_W-1:0]               n_eff;
  logic [CNT_W-1:0]               idx_inc;
  logic                           idx_last;
  tce_pkg::row_t                  row_mask;
  tce_pkg::row_t                  sel_row;
  tce_pkg::row_t [ROWS-1:0]       rows;
  tce_pkg::lane_ctrl_t            ctrl;
  logic                           in_xfer;

  // effective vertex count: zero means one, saturate at the lane count
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (vcount_r > tce_pkg::CFG_W'(ROWS)) begin
      n_eff = CNT_W'(ROWS);
    end else begin
      n_eff = CNT_W'(vcount_r);
    end
  end

  always_comb begin
    for (int j = 0; j < tce_pkg::ROW_W; j++) begin
      row_mask[j] = (j < int'(n_eff));
    end
  end

  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_last = (idx_inc == n_eff);
  // a register write takes the cycle; rows wait until it is done
  assign in_tready = (state_r == ST_LOAD) && !cfg_valid;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = (state_r == ST_LOAD);

  assign ctrl.load_en  = in_xfer;
  assign ctrl.close_en = (state_r == ST_CLOSE);
  assign ctrl.sel      = tce_pkg::VIDX_W'(idx_r);

  for (genvar g = 0; g < ROWS; g++) begin : g_lane
    tce_lane #(
      .LANE_ID (g)
    ) u_lane (
      .clk       (clk),
      .ctrl      (ctrl),
      .wdata     (in_tdata & row_mask),
      .pivot_row (sel_row),
      .row       (rows[g])
    );
  end

  tce_merge #(
    .ROWS (ROWS)
  ) u_merge (
    .rows    (rows),
    .sel     (ctrl.sel),
    .sel_row (sel_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      vcount_r    <= tce_pkg::VCOUNT_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
          end
          // a register write restarts the matrix load
          if (cfg_valid && cfg_ready) begin
            vcount_r <= cfg_data;
            idx_r    <= '0;
          end else if (in_xfer) begin
            if (idx_last) begin
              idx_r   <= '0;
              state_r <= ST_CLOSE;
            end else begin
              idx_r <= idx_inc;
            end
          end
        end
        ST_CLOSE: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (idx_last) begin
            idx_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            idx_r <= idx_inc;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= sel_row;
            out_vtx_r   <= tce_pkg::VIDX_W'(idx_r);
            out_last_r  <= idx_last;
            if (idx_last) begin
              idx_r   <= '0;
              state_r <= ST_LOAD;
            end else begin
              idx_r <= idx_inc;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_vtx_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

### hdl/tce_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_lane
// One matrix row with its own update: loads its row, then ORs in the pivot
// row whenever its own bit at the pivot index is set.
// ----------------------------------------------------------------------------
module tce_lane #(
  parameter int LANE_ID = 0
) (
  input  logic                clk,
  input  tce_pkg::lane_ctrl_t ctrl,
  input  tce_pkg::row_t       wdata,
  input  tce_pkg::row_t       pivot_row,
  output tce_pkg::row_t       row
);

  tce_pkg::row_t row_r;
  tce_pkg::row_t row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctrl.load_en && (ctrl.sel == tce_pkg::VIDX_W'(LANE_ID))) begin
      row_nxt = wdata;
    end else if (ctrl.close_en && row_r[ctrl.sel]) begin
      row_nxt = row_r | pivot_row;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row = row_r;

endmodule

### hdl/tce_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_merge
// Gathers the lane rows and selects the one at the shared index: the pivot
// during closure, the row to emit during output.
// ----------------------------------------------------------------------------
module tce_merge #(
  parameter int ROWS = 32
) (
  input  tce_pkg::row_t [ROWS-1:0] rows,
  input  logic [tce_pkg::VIDX_W-1:0] sel,
  output tce_pkg::row_t             sel_row
);

  localparam int IDX_W = $clog2(ROWS);

  assign sel_row = rows[sel[IDX_W-1:0]];

endmodule

### hdl/tce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks for the transitive closure engine, bound to the top.
// ----------------------------------------------------------------------------
module tce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // rows of one matrix follow back to back in index order
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[36:32] == $past(out_tdata[36:32]) + 5'd1))
    else $error("closure row sequence broken");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:37] == 3'b000)
    else $error("tdata pad bits not zero");

endmodule

bind transitive_closure_engine tce_checker u_tce_checker (.*);

### sim/transitive_closure_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transitive_closure_engine_tb
// Self-checking bench for the transitive closure engine. Adjacency rows are
// streamed in under several vertex counts and idle/stall mixes, including a
// long output hold-off. A local Warshall predictor queues the closure rows
// each completed load should produce, and every output transfer is checked
// against the oldest queued row.
// ----------------------------------------------------------------------------
module transitive_closure_engine_tb;

  localparam int SETTLE_CYCLES = 3 * 32 + 8;

  typedef struct {
    tce_pkg::row_t              reach;
    logic [tce_pkg::VIDX_W-1:0] src;
    logic                       last;
  } closure_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [tce_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata = '0;   // [31:0] adjacency_row
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [39:0]                out_tdata;       // [31:0] closure_row, [36:32] source_vertex
  logic                       out_tlast;       // final_row

  // predictor state
  tce_pkg::row_t              adj_matrix [32];
  int unsigned                rows_in_load;
  logic [tce_pkg::CFG_W-1:0]  vertex_count_q;
  closure_row_t               pending_rows [$];

  int                errors = 0;
  int                tx_idle_pct = 0;
  int                rx_stall_pct = 0;
  int                rx_hold = 0;

  transitive_closure_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("transitive_closure_engine_tb NOT OK");
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic int unsigned active_vertices(logic [tce_pkg::CFG_W-1:0] vc);
    if (vc == 0) return 1;
    if (vc > 32) return 32;
    return vc;
  endfunction

  function automatic void predict_closure(tce_pkg::row_t adj);
    int unsigned   n;
    tce_pkg::row_t pivot;
    closure_row_t  r;
    n = active_vertices(vertex_count_q);
    if (rows_in_load >= n) rows_in_load = 0;
    adj_matrix[rows_in_load] = (n >= 32) ? adj : (adj & ((32'd1 << n) - 1));
    rows_in_load++;
    if (rows_in_load < n) return;
    for (int k = 0; k < n; k++) begin
      pivot = adj_matrix[k];
      for (int i = 0; i < n; i++)
        if (adj_matrix[i][k]) adj_matrix[i] = adj_matrix[i] | pivot;
    end
    for (int i = 0; i < n; i++) begin
      r.reach = adj_matrix[i];
      r.src   = i[tce_pkg::VIDX_W-1:0];
      r.last  = (i + 1 == n);
      pending_rows.push_back(r);
    end
    rows_in_load = 0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    closure_row_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected transfer, closure_row", out_tdata[31:0], 0);
      end else begin
        e = pending_rows.pop_front();
        if (out_tdata[31:0] !== e.reach)
          report_mismatch("closure_row", out_tdata[31:0], e.reach);
        if (out_tdata[36:32] !== e.src)
          report_mismatch("source_vertex", out_tdata[36:32], e.src);
        if (out_tlast !== e.last)
          report_mismatch("final_row", out_tlast, e.last);
      end
    end
  end

  task automatic send_row(tce_pkg::row_t adj);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= adj;
    do @(posedge clk); while (!in_tready);
    predict_closure(adj);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [tce_pkg::CFG_W-1:0] vc);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= vc;
    do @(posedge clk); while (!cfg_ready);
    vertex_count_q = vc;
    rows_in_load   = 0;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tce_pkg::row_t random_row();
    case ($urandom_range(4))
      0: return $urandom & $urandom & $urandom;
      1: return 32'd1 << $urandom_range(31);
      2: return $urandom;
      3: return $urandom & $urandom;
      default: return '0;
    endcase
  endfunction

  // reset count, with the output held off while a full load and one more row
  // are offered
  task automatic test_reset_count_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 600;
    for (int i = 0; i < 33; i++) send_row(random_row());
    drain_results();
  endtask

  task automatic test_single_vertex();
    write_vertex_count(6'd1);
    send_row(32'hFFFF_FFFF);
    send_row(32'h0000_0000);
    write_vertex_count(6'd0);
    send_row(32'hFFFF_FFFE);
    send_row(32'hFFFF_FFFF);
  endtask

  task automatic test_small_graphs();
    write_vertex_count(6'd2);
    send_row(32'h2);
    send_row(32'h1);
    write_vertex_count(6'd3);
    send_row(32'h2);
    send_row(32'h4);
    send_row(32'h1);
    write_vertex_count(6'd4);
    send_row(32'h2);
    send_row(32'h4);
    send_row(32'h8);
    send_row(32'hFFFF_FFF0);
  endtask

  // cfg write mid-load drops the partial matrix
  task automatic test_load_abort();
    write_vertex_count(6'd4);
    send_row(32'hF);
    send_row(32'h1);
    write_vertex_count(6'd3);
    send_row(32'h4);
    send_row(32'h0);
    send_row(32'h2);
  endtask

  task automatic test_saturated_count();
    write_vertex_count(6'd63);
    send_row(32'hFFFF_FFFF);
    for (int i = 1; i < 31; i++) send_row(random_row());
    send_row(32'h0);
  endtask

  task automatic test_random_traffic();
    int          n;
    int unsigned tx_pct [4] = '{0, 67, 0, 22};
    int unsigned rx_pct [4] = '{0, 0, 67, 22};
    for (int mode = 0; mode < 4; mode++) begin
      drain_results();
      tx_idle_pct  = tx_pct[mode];
      rx_stall_pct = rx_pct[mode];
      for (int ld = 0; ld < 3; ld++) begin
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 4);
        write_vertex_count(n[tce_pkg::CFG_W-1:0]);
        repeat ($urandom_range(1, 2))
          for (int i = 0; i < n; i++) send_row(random_row());
        if (n > 1 && $urandom_range(2) == 0)
          repeat ($urandom_range(1, n - 1)) send_row(random_row());
      end
    end
  endtask

  initial begin
    vertex_count_q = tce_pkg::VCOUNT_RESET;
    rows_in_load   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_count_backpressure();
    test_single_vertex();
    test_small_graphs();
    test_load_abort();
    test_saturated_count();
    test_random_traffic();
    drain_results();
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("transitive_closure_engine_tb OK");
    end else begin
      $display("transitive_closure_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
